>>> rtl/core/fcchf_pkg.sv
// ----------------------------------------------------------------------------
// fcchf_pkg
// Shared types, constants, entry decode and the control store of the
// FAT cluster chain head finder.
// ----------------------------------------------------------------------------
package fcchf_pkg;

	localparam int unsigned TableDepth = 65536;
	localparam int unsigned AddrW      = $clog2(TableDepth);
	localparam int unsigned IdxW       = 16;
	localparam int unsigned ValW       = 32;
	localparam int unsigned EntryW     = 28;
	localparam int unsigned CurW       = 17;
	localparam int unsigned CfgIdxW    = 2;
	localparam int unsigned CfgDataW   = 17;

	localparam logic [CurW-1:0] LimCap =
		(TableDepth < 65536) ? CurW'(TableDepth) : CurW'(65536);

	localparam logic [ValW-1:0]   EntryMask = 32'h0FFF_FFFF;
	localparam logic [EntryW-1:0] RsvFirst  = 28'hFFF_FFF0;
	localparam logic [EntryW-1:0] RsvLast   = 28'hFFF_FFF6;
	localparam logic [EntryW-1:0] BadValue  = 28'hFFF_FFF7;

	localparam logic [IdxW-1:0]     FirstClusterRst = 16'd2;
	localparam logic [CfgDataW-1:0] EntryCountRst   = 17'd65536;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_START = 2'd1,
		CMD_FETCH = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_code_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_FIRST_CLUSTER = 2'd0,
		CFG_ENTRY_COUNT   = 2'd1
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]      command;
		logic [IdxW-1:0] entry_index;
		logic [ValW-1:0] raw_word;
	} cmd_t;

	typedef struct packed {
		logic [IdxW-1:0] head_cluster;
		logic            head_valid;
		logic            scan_done;
	} res_t;

	typedef enum logic [3:0] {
		ST_RST_CLR,
		ST_IDLE,
		ST_LOAD,
		ST_START_CLR,
		ST_START_SET,
		ST_SCAN,
		ST_SCAN_CHK,
		ST_WALK_TEST,
		ST_WALK_CHK,
		ST_EMIT_HEAD,
		ST_EMIT_DONE,
		ST_EMIT_ZERO
	} step_t;

	typedef enum logic [2:0] {
		A_CLR,
		A_IDX,
		A_CUR,
		A_HEAD,
		A_NXT
	} addr_sel_t;

	typedef enum logic [2:0] {
		J_ALWAYS,
		J_CLR_MORE,
		J_CUR_GE_LIM,
		J_VIS_OR_DEAD,
		J_NXT_GE_LIM,
		J_NOT_VIS,
		J_DISPATCH
	} jmp_t;

	typedef enum logic [1:0] {
		E_NONE,
		E_ZERO,
		E_HEAD,
		E_DONE
	} emit_t;

	typedef struct packed {
		addr_sel_t addr_sel;
		logic      tbl_we;
		logic      vis_we;
		logic      vis_wd;
		logic      clr_inc;
		logic      cur_first;
		logic      cur_inc;
		logic      head_ld;
		logic      nxt_ld;
		logic      accept;
		emit_t     emit;
		jmp_t      jmp;
		step_t     jmp_tgt;
		step_t     nxt_tgt;
	} ctl_t;

	typedef struct packed {
		logic clr_more;
		logic cur_ge_lim;
		logic vis_or_dead;
		logic nxt_ge_lim;
		logic vis;
		logic out_free;
	} sts_t;

	function automatic logic is_dead(input logic [EntryW-1:0] v);
		return (v == '0) || (v == EntryW'(1)) || (v == BadValue) ||
			((v >= RsvFirst) && (v <= RsvLast));
	endfunction

	function automatic step_t dispatch_step(input logic [1:0] c);
		step_t s;
		unique case (c)
			CMD_LOAD:  s = ST_LOAD;
			CMD_START: s = ST_START_CLR;
			CMD_FETCH: s = ST_SCAN;
			default:   s = ST_EMIT_ZERO;
		endcase
		return s;
	endfunction

	function automatic ctl_t ucode_rom(input step_t s);
		ctl_t w;
		w = '0;
		w.addr_sel = A_CLR;
		w.emit     = E_NONE;
		w.jmp      = J_ALWAYS;
		w.jmp_tgt  = ST_IDLE;
		w.nxt_tgt  = ST_IDLE;
		unique case (s)
			ST_RST_CLR: begin
				w.addr_sel = A_CLR;
				w.vis_we   = 1'b1;
				w.clr_inc  = 1'b1;
				w.jmp      = J_CLR_MORE;
				w.jmp_tgt  = ST_RST_CLR;
				w.nxt_tgt  = ST_IDLE;
			end
			ST_IDLE: begin
				w.accept  = 1'b1;
				w.jmp     = J_DISPATCH;
				w.nxt_tgt = ST_IDLE;
			end
			ST_LOAD: begin
				w.addr_sel = A_IDX;
				w.tbl_we   = 1'b1;
				w.jmp_tgt  = ST_EMIT_ZERO;
			end
			ST_START_CLR: begin
				w.addr_sel = A_CLR;
				w.vis_we   = 1'b1;
				w.clr_inc  = 1'b1;
				w.jmp      = J_CLR_MORE;
				w.jmp_tgt  = ST_START_CLR;
				w.nxt_tgt  = ST_START_SET;
			end
			ST_START_SET: begin
				w.cur_first = 1'b1;
				w.jmp_tgt   = ST_EMIT_ZERO;
			end
			ST_SCAN: begin
				w.addr_sel = A_CUR;
				w.head_ld  = 1'b1;
				w.jmp      = J_CUR_GE_LIM;
				w.jmp_tgt  = ST_EMIT_DONE;
				w.nxt_tgt  = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				w.addr_sel = A_HEAD;
				w.vis_we   = 1'b1;
				w.vis_wd   = 1'b1;
				w.cur_inc  = 1'b1;
				w.nxt_ld   = 1'b1;
				w.jmp      = J_VIS_OR_DEAD;
				w.jmp_tgt  = ST_SCAN;
				w.nxt_tgt  = ST_WALK_TEST;
			end
			ST_WALK_TEST: begin
				w.addr_sel = A_NXT;
				w.jmp      = J_NXT_GE_LIM;
				w.jmp_tgt  = ST_EMIT_HEAD;
				w.nxt_tgt  = ST_WALK_CHK;
			end
			ST_WALK_CHK: begin
				w.addr_sel = A_NXT;
				w.vis_we   = 1'b1;
				w.vis_wd   = 1'b1;
				w.nxt_ld   = 1'b1;
				w.jmp      = J_NOT_VIS;
				w.jmp_tgt  = ST_WALK_TEST;
				w.nxt_tgt  = ST_EMIT_HEAD;
			end
			ST_EMIT_HEAD: begin
				w.emit = E_HEAD;
			end
			ST_EMIT_DONE: begin
				w.emit = E_DONE;
			end
			ST_EMIT_ZERO: begin
				w.emit = E_ZERO;
			end
			default: begin
				w.jmp_tgt = ST_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

>>> rtl/core/fat_cluster_chain_head_finder.sv
// ----------------------------------------------------------------------------
// fat_cluster_chain_head_finder
// Scans a loaded FAT table for chain heads, walking and marking each
// chain, driven by a small microcoded sequencer.
//
// channel | signals                                  | beat
// cmd     | cmd_valid, cmd_stall, cmd                | command, index, raw word
// res     | res_valid, res_stall, res                | head, head_valid, done
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| register write
//
// load and unused command answer with an empty result; start scan
// sweeps the visited map, one entry a cycle; fetch scans entries and
// walks the chain it finds, one memory read a step.
// after reset the visited map is swept likewise, with cmd stalled.
// a waiting result sits in the output register; the sequencer holds at its
// emit step only while that register is full and stalled.
// ----------------------------------------------------------------------------
module fat_cluster_chain_head_finder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_stall,
	input  fcchf_pkg::cmd_t                cmd,
	output logic                           res_valid,
	input  logic                           res_stall,
	output fcchf_pkg::res_t                res,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fcchf_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [fcchf_pkg::CfgDataW-1:0] cfg_data
);

	import fcchf_pkg::*;

	ctl_t ctl;
	sts_t sts;

	assign cfg_ready = 1'b1;

	fcchf_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.command   (cmd.command),
		.sts       (sts),
		.ctl       (ctl),
		.cmd_stall (cmd_stall)
	);

	fcchf_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res_stall (res_stall),
		.sts       (sts),
		.res_valid (res_valid),
		.res       (res)
	);

endmodule

>>> rtl/core/fcchf_ram.sv
// ----------------------------------------------------------------------------
// fcchf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fcchf_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/fcchf_seq.sv
// ----------------------------------------------------------------------------
// fcchf_seq
// Microcode sequencer: step counter, control store lookup and
// conditional jump selection.
// ----------------------------------------------------------------------------
module fcchf_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  logic [1:0]        command,
	input  fcchf_pkg::sts_t   sts,
	output fcchf_pkg::ctl_t   ctl,
	output logic              cmd_stall
);

	import fcchf_pkg::*;

	step_t step_q;
	step_t step_d;
	logic  taken;
	logic  hold;

	assign ctl       = ucode_rom(step_q);
	assign cmd_stall = !ctl.accept;
	assign hold      = (ctl.emit != E_NONE) && !sts.out_free;

	always_comb begin
		unique case (ctl.jmp)
			J_ALWAYS:      taken = 1'b1;
			J_CLR_MORE:    taken = sts.clr_more;
			J_CUR_GE_LIM:  taken = sts.cur_ge_lim;
			J_VIS_OR_DEAD: taken = sts.vis_or_dead;
			J_NXT_GE_LIM:  taken = sts.nxt_ge_lim;
			J_NOT_VIS:     taken = !sts.vis;
			J_DISPATCH:    taken = cmd_valid;
			default:       taken = 1'b1;
		endcase
	end

	always_comb begin
		if (hold) begin
			step_d = step_q;
		end else if (!taken) begin
			step_d = ctl.nxt_tgt;
		end else if (ctl.jmp == J_DISPATCH) begin
			step_d = dispatch_step(command);
		end else begin
			step_d = ctl.jmp_tgt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_RST_CLR;
		end else begin
			step_q <= step_d;
		end
	end

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> (step_q != ST_IDLE))
		else $error("accepted beat did not start a routine");

	a_rst_clr_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == ST_RST_CLR) |=> (step_q == ST_RST_CLR || step_q == ST_IDLE))
		else $error("reset sweep left to a wrong step");

endmodule

>>> rtl/core/fcchf_dpath.sv
// ----------------------------------------------------------------------------
// fcchf_dpath
// Datapath: table and visited memories, cursor, walk registers,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module fcchf_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fcchf_pkg::ctl_t                     ctl,
	input  logic                                cmd_valid,
	input  fcchf_pkg::cmd_t                     cmd,
	input  logic                                cfg_valid,
	input  logic [fcchf_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [fcchf_pkg::CfgDataW-1:0]      cfg_data,
	input  logic                                res_stall,
	output fcchf_pkg::sts_t                     sts,
	output logic                                res_valid,
	output fcchf_pkg::res_t                     res
);

	import fcchf_pkg::*;

	logic [IdxW-1:0]     first_q;
	logic [CfgDataW-1:0] count_q;
	logic [CurW-1:0]     cur_q;
	logic [CurW-1:0]     lim;
	logic [IdxW-1:0]     head_q;
	logic [EntryW-1:0]   nxt_q;
	logic [AddrW-1:0]    clr_q;
	logic [IdxW-1:0]     idx_q;
	logic [EntryW-1:0]   val_q;
	logic                res_valid_q;
	res_t                res_q;

	logic [AddrW-1:0]    addr;
	logic                tbl_we;
	logic [EntryW-1:0]   tbl_rd;
	logic                vis_rd;
	logic                clr_more;
	logic                out_free;

	assign lim      = (count_q > LimCap) ? LimCap : count_q;
	assign clr_more = (clr_q != AddrW'(TableDepth - 1));
	assign out_free = !res_valid_q || !res_stall;
	assign tbl_we   = ctl.tbl_we && (32'(idx_q) < 32'(TableDepth));

	always_comb begin
		unique case (ctl.addr_sel)
			A_CLR:   addr = clr_q;
			A_IDX:   addr = AddrW'(idx_q);
			A_CUR:   addr = AddrW'(cur_q);
			A_HEAD:  addr = AddrW'(head_q);
			A_NXT:   addr = AddrW'(nxt_q);
			default: addr = clr_q;
		endcase
	end

	fcchf_ram #(
		.Width(EntryW),
		.Depth(TableDepth)
	) u_tbl (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (addr),
		.wdata (val_q),
		.raddr (addr),
		.rdata (tbl_rd)
	);

	fcchf_ram #(
		.Width(1),
		.Depth(TableDepth)
	) u_vis (
		.clk   (clk),
		.we    (ctl.vis_we),
		.waddr (addr),
		.wdata (ctl.vis_wd),
		.raddr (addr),
		.rdata (vis_rd)
	);

	always_comb begin
		sts.clr_more    = clr_more;
		sts.cur_ge_lim  = (cur_q >= lim);
		sts.vis_or_dead = vis_rd || is_dead(tbl_rd);
		sts.nxt_ge_lim  = (nxt_q >= EntryW'(lim));
		sts.vis         = vis_rd;
		sts.out_free    = out_free;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q     <= FirstClusterRst;
			count_q     <= EntryCountRst;
			cur_q       <= '0;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_FIRST_CLUSTER: first_q <= cfg_data[IdxW-1:0];
					CFG_ENTRY_COUNT:   count_q <= cfg_data;
					default: ;
				endcase
			end
			if (ctl.cur_first) begin
				cur_q <= {1'b0, first_q};
			end else if (ctl.cur_inc) begin
				cur_q <= cur_q + 1'b1;
			end
			if (ctl.clr_inc) begin
				clr_q <= clr_more ? clr_q + 1'b1 : '0;
			end
			if ((ctl.emit != E_NONE) && out_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (ctl.accept && cmd_valid) begin
			idx_q <= cmd.entry_index;
			val_q <= EntryW'(cmd.raw_word & EntryMask);
		end
		if (ctl.head_ld) begin
			head_q <= cur_q[IdxW-1:0];
		end
		if (ctl.nxt_ld) begin
			nxt_q <= tbl_rd;
		end
		if ((ctl.emit != E_NONE) && out_free) begin
			unique case (ctl.emit)
				E_HEAD:  res_q <= '{head_cluster: head_q, head_valid: 1'b1, scan_done: 1'b0};
				E_DONE:  res_q <= '{head_cluster: '0, head_valid: 1'b0, scan_done: 1'b1};
				default: res_q <= '{head_cluster: '0, head_valid: 1'b0, scan_done: 1'b0};
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_head_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.head_valid) |-> !res_q.scan_done)
		else $error("result flags both head and done");

	a_cursor_past_head: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.emit == E_HEAD) |-> (cur_q > {1'b0, head_q}))
		else $error("cursor not past emitted head");

endmodule

>>> tb/sv/fat_cluster_chain_head_finder_tb.sv
// ----------------------------------------------------------------------------
// fat_cluster_chain_head_finder_tb
// Drives table loads, scan starts and head fetches into the chain head
// finder and checks every result beat against an in-bench model of the
// table, the visited map and the scan cursor. Directed cases cover the
// entry classes, cyclic and out-of-range links and the register extremes.
// Random phases then reprogram the registers, load a small table window,
// and mix fetches with loads, starts and unused commands. The command
// side idles in random bursts while the result side stalls on its own.
// ----------------------------------------------------------------------------
module fat_cluster_chain_head_finder_tb;
	import fcchf_pkg::*;

	localparam logic [EntryW-1:0]  EocFirst     = 28'hFFF_FFF8;
	localparam logic [CfgIdxW-1:0] CfgSpareLo   = 2'd2;
	localparam logic [CfgIdxW-1:0] CfgSpareHi   = 2'd3;
	localparam int                 RandomItems  = 750;
	localparam int                 SettleCycles = 200;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cmd_valid = 1'b0;
	logic                cmd_stall;
	cmd_t                cmd       = '0;
	logic                res_valid;
	logic                res_stall = 1'b0;
	res_t                res;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data  = '0;

	always #5 clk = ~clk;

	fat_cluster_chain_head_finder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// table model
	bit [EntryW-1:0]   fat_mem [TableDepth];
	bit                visited [TableDepth];
	bit                loaded  [TableDepth];
	bit [CurW-1:0]     cursor;
	bit [IdxW-1:0]     first_clu = FirstClusterRst;
	bit [CfgDataW-1:0] ent_cnt   = EntryCountRst;

	res_t head_answers [$];
	res_t want_res;
	int   mismatches = 0;
	int   burst_left = 0;
	int   stall_run  = 0;
	bit   stall_on   = 1'b0;

	function automatic bit entry_is_dead(input bit [EntryW-1:0] v);
		return (v == 0) || (v == 1) || (v == BadValue) || (v >= RsvFirst && v <= RsvLast);
	endfunction

	function automatic int scan_limit();
		int lim;
		lim = int'(ent_cnt);
		if (lim > TableDepth) lim = TableDepth;
		if (lim > 65536) lim = 65536;
		return lim;
	endfunction

	function automatic void walk_chain(input int head, input int lim);
		int c;
		int nxt;
		bit going;
		c = head;
		going = 1'b1;
		while (going) begin
			visited[c] = 1'b1;
			nxt = int'(fat_mem[c]);
			if (nxt >= EocFirst || nxt >= lim || visited[nxt])
				going = 1'b0;
			else
				c = nxt;
		end
	endfunction

	function automatic res_t apply_command(input cmd_t c);
		res_t r;
		int lim;
		int i;
		bit found;
		r = '0;
		case (c.command)
			CMD_LOAD: begin
				if (c.entry_index < TableDepth)
					fat_mem[c.entry_index] = c.raw_word[EntryW-1:0];
			end
			CMD_START: begin
				foreach (visited[k]) visited[k] = 1'b0;
				cursor = {1'b0, first_clu};
			end
			CMD_FETCH: begin
				lim = scan_limit();
				found = 1'b0;
				while (!found && cursor < lim) begin
					i = int'(cursor);
					cursor = cursor + 1'b1;
					if (!visited[i]) begin
						visited[i] = 1'b1;
						if (!entry_is_dead(fat_mem[i])) begin
							walk_chain(i, lim);
							r.head_cluster = i[IdxW-1:0];
							r.head_valid = 1'b1;
							found = 1'b1;
						end
					end
				end
				if (!found) r.scan_done = 1'b1;
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic cmd_t make_cmd(input cmd_code_t op, input logic [IdxW-1:0] idx,
			input logic [ValW-1:0] val);
		cmd_t c;
		c.command = op;
		c.entry_index = idx;
		c.raw_word = val;
		return c;
	endfunction

	// links only name loaded entries or indices at or past the limit
	function automatic logic [ValW-1:0] make_entry(input int base, input int n, input int lim);
		int r;
		logic [EntryW-1:0] v;
		r = $urandom_range(0, 99);
		if (r < 45) v = EntryW'(base + $urandom_range(0, n - 1));
		else if (r < 52) v = EntryW'($urandom_range(0, 1));
		else if (r < 67) v = EntryW'(EocFirst + $urandom_range(0, 7));
		else if (r < 75) v = '0;
		else if (r < 82) v = EntryW'(RsvFirst + $urandom_range(0, 6));
		else if (r < 87) v = BadValue;
		else if (r < 95) v = EntryW'($urandom);
		else v = EntryW'(lim);
		if (v < TableDepth && !loaded[v]) v = EocFirst;
		return {4'($urandom), v};
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("%0t mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic send_beat(input cmd_t c);
		@(negedge clk);
		cmd <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall !== 1'b0);
		head_answers.push_back(apply_command(c));
	endtask

	task automatic issue(input cmd_t c);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				cmd_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		send_beat(c);
	endtask

	task automatic drain_results();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (head_answers.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		drain_results();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		if (idx == CFG_FIRST_CLUSTER) first_clu = data[IdxW-1:0];
		else if (idx == CFG_ENTRY_COUNT) ent_cnt = data;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_entry(input int idx, input logic [ValW-1:0] val);
		loaded[idx] = 1'b1;
		issue(make_cmd(CMD_LOAD, idx[IdxW-1:0], val));
	endtask

	task automatic pulse_cmd(input cmd_code_t op);
		issue(make_cmd(op, IdxW'($urandom), $urandom));
	endtask

	// cursor and visited map straight from reset
	task automatic test_fetch_before_start();
		write_reg(CFG_ENTRY_COUNT, 17'd4);
		load_entry(0, 32'hF000_0003);
		load_entry(1, 32'h0000_0001);
		load_entry(2, 32'h0FFF_FFFF);
		load_entry(3, 32'h5FFF_FFF9);
		pulse_cmd(CMD_FETCH);
		pulse_cmd(CMD_FETCH);
		pulse_cmd(CMD_NOP);
		pulse_cmd(CMD_FETCH);
		pulse_cmd(CMD_FETCH);
	endtask

	// reserved, bad, free link, cycle and link to the limit
	task automatic test_entry_classes();
		write_reg(CFG_FIRST_CLUSTER, 17'd0);
		write_reg(CFG_ENTRY_COUNT, 17'd8);
		load_entry(0, 32'h0000_0005);
		load_entry(1, 32'h0FFF_FFF0);
		load_entry(2, 32'h3FFF_FFF7);
		load_entry(3, 32'hAFFF_FFF6);
		load_entry(4, 32'h0000_0006);
		load_entry(5, 32'h0000_0000);
		load_entry(6, 32'h0000_0004);
		load_entry(7, 32'h0000_0008);
		load_entry(8, 32'h0FFF_FFF8);
		pulse_cmd(CMD_START);
		repeat (4) pulse_cmd(CMD_FETCH);
	endtask

	task automatic test_register_extremes();
		write_reg(CFG_FIRST_CLUSTER, 17'h1FFFF);
		write_reg(CFG_ENTRY_COUNT, 17'h10000);
		load_entry(TableDepth - 1, 32'hFFFF_FFFF);
		pulse_cmd(CMD_START);
		pulse_cmd(CMD_FETCH);
		pulse_cmd(CMD_FETCH);
		write_reg(CFG_ENTRY_COUNT, 17'd0);
		pulse_cmd(CMD_FETCH);
		write_reg(CfgSpareLo, 17'h0FFFF);
		write_reg(CFG_FIRST_CLUSTER, 17'd100);
		write_reg(CFG_ENTRY_COUNT, 17'd50);
		write_reg(CfgSpareHi, 17'h1FFFF);
		pulse_cmd(CMD_START);
		pulse_cmd(CMD_FETCH);
	endtask

	task automatic test_random_phases();
		int sent;
		int base;
		int n;
		int lim;
		int len;
		int r;
		int k;
		sent = 0;
		while (sent < RandomItems) begin
			case ($urandom_range(0, 3))
				0, 1: begin
					n = $urandom_range(1, 48);
					base = $urandom_range(0, 300);
					lim = base + n;
				end
				2: begin
					n = $urandom_range(1, 40);
					base = TableDepth - n;
					lim = TableDepth;
				end
				default: begin
					n = $urandom_range(1, 48);
					base = $urandom_range(0, 20000);
					lim = base + n;
				end
			endcase
			write_reg(CFG_FIRST_CLUSTER, {1'($urandom), base[IdxW-1:0]});
			write_reg(CFG_ENTRY_COUNT, lim[CfgDataW-1:0]);
			if ($urandom_range(0, 1))
				write_reg($urandom_range(0, 1) ? CfgSpareLo : CfgSpareHi, CfgDataW'($urandom));
			for (k = base; k < lim; k++) loaded[k] = 1'b1;
			for (k = base; k < lim; k++) load_entry(k, make_entry(base, n, lim));
			pulse_cmd(CMD_START);
			sent += n + 1;
			len = $urandom_range(90, 150);
			repeat (len) begin
				r = $urandom_range(0, 399);
				if (r == 0) begin
					pulse_cmd(CMD_START);
					sent++;
				end else if (r < 330 && r >= 200) begin
					load_entry(base + $urandom_range(0, n - 1), make_entry(base, n, lim));
					sent++;
				end else if (r < 360 && r >= 330) begin
					load_entry($urandom_range(0, TableDepth - 1), make_entry(base, n, lim));
					sent++;
				end else if (r < 385 && r >= 360) begin
					pulse_cmd(CMD_NOP);
				end else if (r < 390 && r >= 385) begin
					drain_results();
				end else begin
					pulse_cmd(CMD_FETCH);
					sent++;
				end
			end
		end
	endtask

	// result side stall pattern
	always @(negedge clk) begin
		if (stall_run == 0) begin
			stall_run = $urandom_range(1, 16);
			stall_on = ($urandom_range(0, 3) == 0);
		end
		stall_run--;
		res_stall <= stall_on;
	end

	always @(posedge clk) begin
		if (arst_n && res_valid === 1'b1 && res_stall === 1'b0) begin
			if (head_answers.size() == 0) begin
				flag_mismatch("result beat with nothing awaited");
			end else begin
				want_res = head_answers.pop_front();
				if (res.head_cluster !== want_res.head_cluster)
					flag_mismatch($sformatf("head_cluster got %0d want %0d",
						res.head_cluster, want_res.head_cluster));
				if (res.head_valid !== want_res.head_valid)
					flag_mismatch($sformatf("head_valid got %b want %b",
						res.head_valid, want_res.head_valid));
				if (res.scan_done !== want_res.scan_done)
					flag_mismatch($sformatf("scan_done got %b want %b",
						res.scan_done, want_res.scan_done));
			end
		end
	end

	initial begin
		#100_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_fetch_before_start();
		test_entry_classes();
		test_register_extremes();
		test_random_phases();
		drain_results();
		repeat (SettleCycles) @(posedge clk);
		if (mismatches == 0 && head_answers.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/fcchf_pkg.sv
rtl/core/fcchf_ram.sv
rtl/core/fcchf_seq.sv
rtl/core/fcchf_dpath.sv
rtl/core/fat_cluster_chain_head_finder.sv
tb/sv/fat_cluster_chain_head_finder_tb.sv
